/* sv/mmd_pkg.sv */
package mmd_pkg;

  // Access codes carried by the operation field
  typedef enum logic [1:0] {
    OP_READ    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_WRITE16 = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_UNMAPPED  = 2'd1,
    STAT_SECOND_UM = 2'd2
  } status_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WRITE_HI
  } state_t;

  // All six stores share one byte array:
  //   0000-1FFF video RAM, 2000-3FFF external RAM, 4000-5FFF work RAM,
  //   6000-609F sprite table, 6100-617F I/O bytes, 6180-61FE high RAM
  localparam int unsigned MemDepth = 25088;
  localparam int unsigned IdxW     = 15;

  localparam logic [IdxW-1:0] SpriteBase = 15'h6000;
  localparam logic [IdxW-1:0] IoBase     = 15'h6100;
  localparam logic [IdxW-1:0] WorkBase   = 15'h4000;

  typedef struct packed {
    logic            hit;
    logic [IdxW-1:0] idx;
  } map_t;

  // Address decode into the shared array; hit low for unmapped addresses
  function automatic map_t mmd_decode(input logic [15:0] a);
    map_t m;
    m.hit = 1'b1;
    m.idx = '0;
    if (a inside {[16'h8000:16'hDFFF]}) begin
      m.idx = a[14:0];
    end else if (a inside {[16'hE000:16'hFDFF]}) begin
      // echo of work RAM
      m.idx = WorkBase | {2'b00, a[12:0]};
    end else if (a inside {[16'hFE00:16'hFE9F]}) begin
      m.idx = SpriteBase | {7'd0, a[7:0]};
    end else if (a inside {[16'hFF00:16'hFFFE]}) begin
      // I/O bytes followed by high RAM
      m.idx = IoBase | {7'd0, a[7:0]};
    end else begin
      m.hit = 1'b0;
    end
    return m;
  endfunction

endpackage

/* sv/memory_map_decoder_unit.sv */
// Result path: byte write, unmapped access and undefined code load the result register
//   on acceptance; a byte read passes the memory read register and ST_READ first, a 16-bit write ST_WRITE_HI.
// Acceptance: only in ST_IDLE with the result register free, so reads and 16-bit writes
//   hold off the next item; a 16-bit write stores its two bytes one after the other.
// Reset (rst, synchronous): sequencer idle, no result pending; memory contents
//   are not cleared and read as undefined until written.
module memory_map_decoder_unit
  import mmd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [15:0] address,
  input  logic [15:0] write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  read_data,
  output logic [1:0]  status
);

  state_t state, state_next;

  logic            accept;
  map_t            lo_map, hi_map;

  // second byte of a 16-bit write, held for the following cycle
  logic            hi_hit;
  logic [IdxW-1:0] hi_idx;
  logic [7:0]      hi_data;

  // memory port
  logic [7:0]      mem [0:MemDepth-1];
  logic            mem_we;
  logic [IdxW-1:0] mem_wa;
  logic [7:0]      mem_wd;
  logic [7:0]      mem_q;

  // result load
  logic            load;
  logic [7:0]      ld_rd;
  status_t         ld_st;

  // take a new item only when idle and the result register is free
  assign in_stall = (state != ST_IDLE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    lo_map = mmd_decode(address);
    hi_map = mmd_decode(address + 16'd1);
  end

  // write port select: first byte on accept, second byte in ST_WRITE_HI in the next cycle
  always_comb begin
    mem_we = 1'b0;
    mem_wa = lo_map.idx;
    mem_wd = write_data[7:0];
    if (state == ST_WRITE_HI) begin
      mem_we = hi_hit;
      mem_wa = hi_idx;
      mem_wd = hi_data;
    end else if (accept && lo_map.hit &&
                 (operation == OP_WRITE || operation == OP_WRITE16)) begin
      mem_we = 1'b1;
    end
  end

  // one item at a time, so a read never overlaps a write to the same byte
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q <= mem[lo_map.idx];
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and result load
  always_comb begin
    state_next = state;
    load       = 1'b0;
    ld_rd      = 8'd0;
    ld_st      = STAT_OK;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (operation)
            OP_READ: begin
              if (lo_map.hit) begin
                state_next = ST_READ;
              end else begin
                load  = 1'b1;
                ld_st = STAT_UNMAPPED;
              end
            end
            OP_WRITE: begin
              load  = 1'b1;
              ld_st = lo_map.hit ? STAT_OK : STAT_UNMAPPED;
            end
            OP_WRITE16: begin
              if (lo_map.hit) begin
                state_next = ST_WRITE_HI;
              end else begin
                load  = 1'b1;
                ld_st = STAT_UNMAPPED;
              end
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        load       = 1'b1;
        ld_rd      = mem_q;
        state_next = ST_IDLE;
      end
      ST_WRITE_HI: begin
        load       = 1'b1;
        ld_st      = hi_hit ? STAT_OK : STAT_SECOND_UM;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // capture the second byte of a 16-bit write (loaded on every accepted item)
  always_ff @(posedge clk) begin
    if (accept) begin
      hi_hit  <= hi_map.hit;
      hi_idx  <= hi_map.idx;
      hi_data <= write_data[15:8];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      read_data <= ld_rd;
      status    <= ld_st;
    end
  end

endmodule

/* sv/mmd_checker.sv */
module mmd_checker
  import mmd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  operation,
  input logic [15:0] address,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  read_data,
  input logic [1:0]  status
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(status))
    else $error("stalled result changed");

  // only an ok read may return a nonzero byte
  a_rd_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STAT_OK |-> read_data == 8'd0)
    else $error("nonzero read_data with error status");

  // an access into the ROM area reports unmapped in the next cycle
  a_rom_unmapped: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !address[15] &&
    (operation == OP_READ || operation == OP_WRITE || operation == OP_WRITE16)
    |=> out_valid && status == STAT_UNMAPPED && read_data == 8'd0)
    else $error("ROM area access not reported unmapped");

  // a read or 16-bit write into 8000-DFFF stalls the input in the cycle after it is accepted
  a_two_cycle: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && address[15] && (address[14:13] != 2'b11) &&
    (operation == OP_READ || operation == OP_WRITE16) |=> in_stall)
    else $error("second cycle of access not held off");

endmodule

bind memory_map_decoder_unit mmd_checker u_mmd_checker (.*);
